// ----- rtl/dimuon_pair_mass_unit_macros.svh -----
// assertion macros shared by the dimuon pair mass rtl
`ifndef DIMUON_PAIR_MASS_UNIT_MACROS_SVH
`define DIMUON_PAIR_MASS_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define DPM_ASSERT_IMP(name, clock, rstn, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("dpm assertion failed");

// next-cycle implication, held off during reset
`define DPM_ASSERT_NEXT(name, clock, rstn, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("dpm assertion failed");

`endif

// ----- rtl/dpm_pkg.sv -----
// shared types, constants and helpers of the dimuon pair mass unit
package dpm_pkg;

	localparam int MAX_MUONS_DEF  = 8;
	localparam int COMP_WIDTH_DEF = 20;

	localparam int E_W     = 19;
	localparam int PT_W    = 20;
	localparam int EVT_W   = 32;
	localparam int IDXO_W  = 3;
	localparam int CFG_W   = 19;
	localparam int MINC_W  = 4;
	localparam int SQ_IN_W = 33;
	localparam int SQ_W    = 64;
	localparam int ROOT_W  = 32;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_PT_MIN    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT = 1'b1;

	localparam logic [PT_W-1:0] PT_SAT = '1;

	// sequencer states
	typedef enum logic [4:0] {
		S_IDLE,
		S_PT_X,
		S_PT_Y,
		S_PT_ROOT,
		S_PT_WAIT,
		S_CLOSE,
		S_COUNT,
		S_SCAN,
		S_LD_I,
		S_LD_J,
		S_SQ_X,
		S_SQ_Y,
		S_SQ_Z,
		S_SQ_E,
		S_M2,
		S_MASS_WAIT,
		S_MOM_WAIT,
		S_EMIT,
		S_CLEAR
	} state_t;

	// square root unit status
	typedef struct packed {
		logic busy;
		logic done;
	} root_stat_t;

	// 64-bit add that sticks at all ones
	function automatic logic [SQ_W-1:0] sat_add64(input logic [SQ_W-1:0] a,
			input logic [SQ_W-1:0] b);
		logic [SQ_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add64 = s[SQ_W] ? '1 : s[SQ_W-1:0];
	endfunction

	// clamp a root to the 20-bit result range
	function automatic logic [PT_W-1:0] sat20(input logic [ROOT_W-1:0] v);
		sat20 = (v > ROOT_W'(PT_SAT)) ? PT_SAT : v[PT_W-1:0];
	endfunction

endpackage

// ----- rtl/dpm_sqr.sv -----
// registered squarer with saturation for magnitudes of 2^32 and up
module dpm_sqr (
	input  logic                        clk,
	input  logic [dpm_pkg::SQ_IN_W-1:0] a,
	output logic [dpm_pkg::SQ_W-1:0]    sq
);

	logic [dpm_pkg::SQ_W-1:0] sq_q;

	// one 32x32 product per cycle
	always_ff @(posedge clk) begin
		if (a[dpm_pkg::SQ_IN_W-1])
			sq_q <= '1;
		else
			sq_q <= a[dpm_pkg::SQ_IN_W-2:0] * a[dpm_pkg::SQ_IN_W-2:0];
	end

	assign sq = sq_q;

endmodule

// ----- rtl/dpm_isqrt.sv -----
// iterative floor square root, one result bit per cycle
module dpm_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [dpm_pkg::SQ_W-1:0]   op,
	output dpm_pkg::root_stat_t        stat,
	output logic [dpm_pkg::ROOT_W-1:0] root
);

	localparam int REM_W = dpm_pkg::ROOT_W + 2;
	localparam int CNT_W = $clog2(dpm_pkg::ROOT_W);

	logic                       busy_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [dpm_pkg::SQ_W-1:0]   op_q;
	logic [REM_W-1:0]           rem_q;
	logic [dpm_pkg::ROOT_W-1:0] root_q;

	logic [REM_W+1:0] rem_sh;
	logic [REM_W+1:0] trial;
	logic             ge;
	logic [REM_W+1:0] rem_diff;

	// trial subtract of the next bit pair
	always_comb begin
		rem_sh   = {rem_q, op_q[dpm_pkg::SQ_W-1 -: 2]};
		trial    = {2'b00, root_q, 2'b01};
		ge       = rem_sh >= trial;
		rem_diff = ge ? (rem_sh - trial) : rem_sh;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(dpm_pkg::ROOT_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= op;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			op_q   <= {op_q[dpm_pkg::SQ_W-3:0], 2'b00};
			rem_q  <= rem_diff[REM_W-1:0];
			root_q <= {root_q[dpm_pkg::ROOT_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root      = root_q;

	`include "dimuon_pair_mass_unit_macros.svh"

	`DPM_ASSERT_IMP(a_done_not_busy, clk, arst_n, done_q, !busy_q)
	`DPM_ASSERT_NEXT(a_start_busy, clk, arst_n, start, busy_q && !done_q)

endmodule

// ----- rtl/dpm_store.sv -----
// muon store: four-vector and pt per slot, one indexed read port plus all pt values
module dpm_store #(
	parameter int MAX_MUONS  = dpm_pkg::MAX_MUONS_DEF,
	parameter int COMP_WIDTH = dpm_pkg::COMP_WIDTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic                                      pt_we,
	input  logic [$clog2(MAX_MUONS)-1:0]              wr_idx,
	input  logic [dpm_pkg::E_W-1:0]                   wr_energy,
	input  logic signed [COMP_WIDTH-1:0]              wr_px,
	input  logic signed [COMP_WIDTH-1:0]              wr_py,
	input  logic signed [COMP_WIDTH-1:0]              wr_pz,
	input  logic [dpm_pkg::PT_W-1:0]                  wr_pt,
	input  logic [$clog2(MAX_MUONS)-1:0]              rd_idx,
	output logic [dpm_pkg::E_W-1:0]                   rd_energy,
	output logic signed [COMP_WIDTH-1:0]              rd_px,
	output logic signed [COMP_WIDTH-1:0]              rd_py,
	output logic signed [COMP_WIDTH-1:0]              rd_pz,
	output logic [dpm_pkg::PT_W-1:0]                  rd_pt,
	output logic [MAX_MUONS-1:0][dpm_pkg::PT_W-1:0]   pt_all
);

	logic [dpm_pkg::E_W-1:0]     energy_q [MAX_MUONS];
	logic signed [COMP_WIDTH-1:0] px_q    [MAX_MUONS];
	logic signed [COMP_WIDTH-1:0] py_q    [MAX_MUONS];
	logic signed [COMP_WIDTH-1:0] pz_q    [MAX_MUONS];
	logic [MAX_MUONS-1:0][dpm_pkg::PT_W-1:0] pt_q;

	// slot writes
	always_ff @(posedge clk) begin
		if (we) begin
			energy_q[wr_idx] <= wr_energy;
			px_q[wr_idx]     <= wr_px;
			py_q[wr_idx]     <= wr_py;
			pz_q[wr_idx]     <= wr_pz;
		end
		if (pt_we)
			pt_q[wr_idx] <= wr_pt;
	end

	// single indexed read port; pt_all gives every stored pt
	assign rd_energy = energy_q[rd_idx];
	assign rd_px     = px_q[rd_idx];
	assign rd_py     = py_q[rd_idx];
	assign rd_pz     = pz_q[rd_idx];
	assign rd_pt     = pt_q[rd_idx];
	assign pt_all    = pt_q;

endmodule

// ----- rtl/dimuon_pair_mass_unit.sv -----
// dimuon pair mass unit: muon store, pair sequencer and shared arithmetic
//
//   channel   dir   handshake             payload
//   input     in    in_valid / in_ready   energy mom_x mom_y mom_z event_id has_muon last_muon
//   output    out   out_valid / out_ready out_event_id pair_mass pair_momentum first_pt
//                                         second_pt first_index second_index overflow last_pair
//   config    in    cfg_we                cfg_index cfg_data
//
// a stored muon takes two squares on the shared multiplier, then a 32-step square
// root. closing an event passes the close and count states, then the pair scan, and
// each passing pair takes two 32-step roots on the one root unit.
// in_ready is high only in the idle state; one request is worked on at a time.
// a result waits in the output register while the sequencer goes on to the next pair.
// arst_n clears control state and sets the two configuration registers to their defaults; no clearing pass.
module dimuon_pair_mass_unit #(
	parameter int MAX_MUONS  = dpm_pkg::MAX_MUONS_DEF,
	parameter int COMP_WIDTH = dpm_pkg::COMP_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [dpm_pkg::E_W-1:0]         energy,
	input  logic signed [COMP_WIDTH-1:0]    mom_x,
	input  logic signed [COMP_WIDTH-1:0]    mom_y,
	input  logic signed [COMP_WIDTH-1:0]    mom_z,
	input  logic [dpm_pkg::EVT_W-1:0]       event_id,
	input  logic                            has_muon,
	input  logic                            last_muon,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [dpm_pkg::EVT_W-1:0]       out_event_id,
	output logic [dpm_pkg::PT_W-1:0]        pair_mass,
	output logic [dpm_pkg::PT_W-1:0]        pair_momentum,
	output logic [dpm_pkg::PT_W-1:0]        first_pt,
	output logic [dpm_pkg::PT_W-1:0]        second_pt,
	output logic [dpm_pkg::IDXO_W-1:0]      first_index,
	output logic [dpm_pkg::IDXO_W-1:0]      second_index,
	output logic                            overflow,
	output logic                            last_pair,
	input  logic                            cfg_we,
	input  logic [dpm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dpm_pkg::CFG_W-1:0]       cfg_data
);

	localparam int SW     = COMP_WIDTH + 1;
	localparam int CNT_W  = $clog2(MAX_MUONS + 1);
	localparam int IDX_W  = $clog2(MAX_MUONS);
	localparam int NPAIR  = MAX_MUONS * (MAX_MUONS - 1) / 2;
	localparam int PAIR_W = $clog2(NPAIR + 1);
	localparam int PROD_W = 2 * CNT_W;

	// magnitude of a signed component or sum, zero-extended to the squarer width
	function automatic logic [dpm_pkg::SQ_IN_W-1:0] mag(input logic signed [SW-1:0] v);
		logic [SW-1:0] u;
		u = v[SW-1] ? SW'(-v) : SW'(v);
		mag = dpm_pkg::SQ_IN_W'(u);
	endfunction

	dpm_pkg::state_t state_q, state_nx;

	// configuration
	logic [dpm_pkg::CFG_W-1:0]  pt_min_q;
	logic [dpm_pkg::MINC_W-1:0] min_count_q;

	// event state
	logic [CNT_W-1:0]          count_q;
	logic                      overflow_q;
	logic [dpm_pkg::EVT_W-1:0] event_q;
	logic                      last_q;
	logic signed [COMP_WIDTH-1:0] px_q, py_q;

	// pair walk
	logic [MAX_MUONS-1:0] pass_q;
	logic [MAX_MUONS-1:0] pass_nx;
	logic [CNT_W-1:0]     i_q, j_q;
	logic [PAIR_W-1:0]    total_q, emitted_q;
	logic [CNT_W-1:0]     pcount;
	logic [PROD_W-1:0]    pprod;

	// pair operands and results
	logic [dpm_pkg::E_W-1:0]      ei_q;
	logic signed [COMP_WIDTH-1:0] pxi_q, pyi_q, pzi_q;
	logic [dpm_pkg::PT_W-1:0]     pti_q, ptj_q;
	logic [dpm_pkg::E_W:0]        sum_e_q;
	logic signed [SW-1:0]         sx_q, sy_q, sz_q;
	logic [dpm_pkg::SQ_W-1:0]     p2_q;
	logic [dpm_pkg::PT_W-1:0]     mass_q, mom_q;

	// output register
	logic                          out_valid_q;
	logic [dpm_pkg::EVT_W-1:0]     out_event_q;
	logic [dpm_pkg::PT_W-1:0]      out_mass_q, out_mom_q, out_pt1_q, out_pt2_q;
	logic [dpm_pkg::IDXO_W-1:0]    out_idx1_q, out_idx2_q;
	logic                          out_ovf_q, out_last_q;

	// shared units
	logic [dpm_pkg::SQ_IN_W-1:0] sq_a;
	logic [dpm_pkg::SQ_W-1:0]    sq;
	logic                        root_start;
	logic [dpm_pkg::SQ_W-1:0]    root_op;
	dpm_pkg::root_stat_t         root_stat;
	logic [dpm_pkg::ROOT_W-1:0]  root;

	// store access
	logic                         st_we, pt_we;
	logic [IDX_W-1:0]             rd_idx;
	logic [dpm_pkg::E_W-1:0]      rd_energy;
	logic signed [COMP_WIDTH-1:0] rd_px, rd_py, rd_pz;
	logic [dpm_pkg::PT_W-1:0]     rd_pt;
	logic [MAX_MUONS-1:0][dpm_pkg::PT_W-1:0] pt_all;

	logic in_acc, room, out_free, out_load;
	logic pass_i, pass_j;
	logic [dpm_pkg::SQ_W-1:0] e2_gt_p2_diff;

	assign in_acc   = in_valid && in_ready;
	assign room     = count_q < CNT_W'(MAX_MUONS);
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == dpm_pkg::S_EMIT) && out_free;
	assign pass_i   = pass_q[i_q[IDX_W-1:0]];
	assign pass_j   = pass_q[j_q[IDX_W-1:0]];
	assign e2_gt_p2_diff = (sq > p2_q) ? (sq - p2_q) : '0;

	dpm_store #(
		.MAX_MUONS (MAX_MUONS),
		.COMP_WIDTH(COMP_WIDTH)
	) u_store (
		.clk      (clk),
		.we       (st_we),
		.pt_we    (pt_we),
		.wr_idx   (count_q[IDX_W-1:0]),
		.wr_energy(energy),
		.wr_px    (mom_x),
		.wr_py    (mom_y),
		.wr_pz    (mom_z),
		.wr_pt    (dpm_pkg::sat20(root)),
		.rd_idx   (rd_idx),
		.rd_energy(rd_energy),
		.rd_px    (rd_px),
		.rd_py    (rd_py),
		.rd_pz    (rd_pz),
		.rd_pt    (rd_pt),
		.pt_all   (pt_all)
	);

	dpm_sqr u_sqr (
		.clk(clk),
		.a  (sq_a),
		.sq (sq)
	);

	dpm_isqrt u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (root_start),
		.op    (root_op),
		.stat  (root_stat),
		.root  (root)
	);

	// pass mask of stored muons against the pt cut
	always_comb begin
		for (int k = 0; k < MAX_MUONS; k++)
			pass_nx[k] = (CNT_W'(k) < count_q) && (pt_all[k] >= {1'b0, pt_min_q});
	end

	// number of passing muons and twice the number of pairs among them
	always_comb begin
		pcount = CNT_W'($countones(pass_q));
		pprod  = PROD_W'(pcount) * PROD_W'(pcount - 1'b1);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			dpm_pkg::S_IDLE: begin
				if (in_acc) begin
					if (has_muon && room)
						state_nx = dpm_pkg::S_PT_X;
					else if (last_muon)
						state_nx = dpm_pkg::S_CLOSE;
				end
			end
			dpm_pkg::S_PT_X:    state_nx = dpm_pkg::S_PT_Y;
			dpm_pkg::S_PT_Y:    state_nx = dpm_pkg::S_PT_ROOT;
			dpm_pkg::S_PT_ROOT: state_nx = dpm_pkg::S_PT_WAIT;
			dpm_pkg::S_PT_WAIT: begin
				if (root_stat.done)
					state_nx = last_q ? dpm_pkg::S_CLOSE : dpm_pkg::S_IDLE;
			end
			dpm_pkg::S_CLOSE:   state_nx = dpm_pkg::S_COUNT;
			dpm_pkg::S_COUNT: begin
				if ((dpm_pkg::MINC_W'(count_q) < min_count_q) || (pcount < CNT_W'(2)))
					state_nx = dpm_pkg::S_CLEAR;
				else
					state_nx = dpm_pkg::S_SCAN;
			end
			dpm_pkg::S_SCAN: begin
				if (({1'b0, i_q} + 1'b1) >= {1'b0, count_q})
					state_nx = dpm_pkg::S_CLEAR;
				else if (!pass_i || (j_q >= count_q) || !pass_j)
					state_nx = dpm_pkg::S_SCAN;
				else
					state_nx = dpm_pkg::S_LD_I;
			end
			dpm_pkg::S_LD_I:    state_nx = dpm_pkg::S_LD_J;
			dpm_pkg::S_LD_J:    state_nx = dpm_pkg::S_SQ_X;
			dpm_pkg::S_SQ_X:    state_nx = dpm_pkg::S_SQ_Y;
			dpm_pkg::S_SQ_Y:    state_nx = dpm_pkg::S_SQ_Z;
			dpm_pkg::S_SQ_Z:    state_nx = dpm_pkg::S_SQ_E;
			dpm_pkg::S_SQ_E:    state_nx = dpm_pkg::S_M2;
			dpm_pkg::S_M2:      state_nx = dpm_pkg::S_MASS_WAIT;
			dpm_pkg::S_MASS_WAIT: begin
				if (root_stat.done)
					state_nx = dpm_pkg::S_MOM_WAIT;
			end
			dpm_pkg::S_MOM_WAIT: begin
				if (root_stat.done)
					state_nx = dpm_pkg::S_EMIT;
			end
			dpm_pkg::S_EMIT: begin
				if (out_free)
					state_nx = dpm_pkg::S_SCAN;
			end
			dpm_pkg::S_CLEAR:   state_nx = dpm_pkg::S_IDLE;
			default:            state_nx = dpm_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready   = 1'b0;
		st_we      = 1'b0;
		pt_we      = 1'b0;
		rd_idx     = i_q[IDX_W-1:0];
		sq_a       = '0;
		root_start = 1'b0;
		root_op    = p2_q;
		unique case (state_q)
			dpm_pkg::S_IDLE: begin
				in_ready = 1'b1;
				st_we    = in_valid && has_muon && room;
			end
			dpm_pkg::S_PT_X: sq_a = mag({px_q[COMP_WIDTH-1], px_q});
			dpm_pkg::S_PT_Y: sq_a = mag({py_q[COMP_WIDTH-1], py_q});
			dpm_pkg::S_PT_ROOT: begin
				root_start = 1'b1;
				root_op    = dpm_pkg::sat_add64(p2_q, sq);
			end
			dpm_pkg::S_PT_WAIT: pt_we = root_stat.done;
			dpm_pkg::S_LD_J:    rd_idx = j_q[IDX_W-1:0];
			dpm_pkg::S_SQ_X:    sq_a = mag(sx_q);
			dpm_pkg::S_SQ_Y:    sq_a = mag(sy_q);
			dpm_pkg::S_SQ_Z:    sq_a = mag(sz_q);
			dpm_pkg::S_SQ_E:    sq_a = dpm_pkg::SQ_IN_W'(sum_e_q);
			dpm_pkg::S_M2: begin
				root_start = 1'b1;
				root_op    = e2_gt_p2_diff;
			end
			dpm_pkg::S_MASS_WAIT: root_start = root_stat.done;
			default: ;
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dpm_pkg::S_IDLE;
			pt_min_q    <= dpm_pkg::CFG_W'(8);
			min_count_q <= dpm_pkg::MINC_W'(2);
			count_q     <= '0;
			overflow_q  <= 1'b0;
			event_q     <= '0;
			out_valid_q <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			emitted_q   <= '0;
			total_q     <= '0;
		end else begin
			state_q <= state_nx;

			// configuration writes
			if (cfg_we) begin
				unique case (cfg_index)
					dpm_pkg::REG_PT_MIN:    pt_min_q    <= cfg_data;
					dpm_pkg::REG_MIN_COUNT: min_count_q <= cfg_data[dpm_pkg::MINC_W-1:0];
					default: ;
				endcase
			end

			// request intake
			if (in_acc) begin
				event_q <= event_id;
				if (has_muon && !room)
					overflow_q <= 1'b1;
			end

			if (pt_we)
				count_q <= count_q + 1'b1;

			// pair walk setup
			if (state_q == dpm_pkg::S_COUNT) begin
				total_q   <= PAIR_W'(pprod >> 1);
				emitted_q <= '0;
				i_q       <= '0;
				j_q       <= CNT_W'(1);
			end

			// scan to the next passing pair
			if (state_q == dpm_pkg::S_SCAN) begin
				if (!pass_i || (j_q >= count_q)) begin
					i_q <= i_q + 1'b1;
					j_q <= i_q + CNT_W'(2);
				end else if (!pass_j) begin
					j_q <= j_q + 1'b1;
				end
			end

			if (out_load) begin
				emitted_q <= emitted_q + 1'b1;
				j_q       <= j_q + 1'b1;
			end

			// output register
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (state_q == dpm_pkg::S_CLEAR) begin
				count_q    <= '0;
				overflow_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			last_q <= last_muon;
			px_q   <= mom_x;
			py_q   <= mom_y;
		end
		if (state_q == dpm_pkg::S_CLOSE)
			pass_q <= pass_nx;
		if (state_q == dpm_pkg::S_PT_Y)
			p2_q <= sq;
		if (state_q == dpm_pkg::S_LD_I) begin
			ei_q  <= rd_energy;
			pxi_q <= rd_px;
			pyi_q <= rd_py;
			pzi_q <= rd_pz;
			pti_q <= rd_pt;
		end
		if (state_q == dpm_pkg::S_LD_J) begin
			sum_e_q <= {1'b0, ei_q} + {1'b0, rd_energy};
			sx_q    <= {pxi_q[COMP_WIDTH-1], pxi_q} + {rd_px[COMP_WIDTH-1], rd_px};
			sy_q    <= {pyi_q[COMP_WIDTH-1], pyi_q} + {rd_py[COMP_WIDTH-1], rd_py};
			sz_q    <= {pzi_q[COMP_WIDTH-1], pzi_q} + {rd_pz[COMP_WIDTH-1], rd_pz};
			ptj_q   <= rd_pt;
		end
		if (state_q == dpm_pkg::S_SQ_Y)
			p2_q <= sq;
		if ((state_q == dpm_pkg::S_SQ_Z) || (state_q == dpm_pkg::S_SQ_E))
			p2_q <= dpm_pkg::sat_add64(p2_q, sq);
		if ((state_q == dpm_pkg::S_MASS_WAIT) && root_stat.done)
			mass_q <= dpm_pkg::sat20(root);
		if ((state_q == dpm_pkg::S_MOM_WAIT) && root_stat.done)
			mom_q <= dpm_pkg::sat20(root);
		if (out_load) begin
			out_event_q <= event_q;
			out_mass_q  <= mass_q;
			out_mom_q   <= mom_q;
			out_pt1_q   <= pti_q;
			out_pt2_q   <= ptj_q;
			out_idx1_q  <= dpm_pkg::IDXO_W'(i_q);
			out_idx2_q  <= dpm_pkg::IDXO_W'(j_q);
			out_ovf_q   <= overflow_q;
			out_last_q  <= (emitted_q == (total_q - 1'b1));
		end
	end

	assign out_valid     = out_valid_q;
	assign out_event_id  = out_event_q;
	assign pair_mass     = out_mass_q;
	assign pair_momentum = out_mom_q;
	assign first_pt      = out_pt1_q;
	assign second_pt     = out_pt2_q;
	assign first_index   = out_idx1_q;
	assign second_index  = out_idx2_q;
	assign overflow      = out_ovf_q;
	assign last_pair     = out_last_q;

	`include "dimuon_pair_mass_unit_macros.svh"

	`DPM_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_MUONS))
	`DPM_ASSERT_IMP(a_root_free, clk, arst_n, root_start, !root_stat.busy)
	`DPM_ASSERT_IMP(a_emit_bound, clk, arst_n, out_load, emitted_q < total_q)
	`DPM_ASSERT_NEXT(a_busy_after_store, clk, arst_n, st_we, !in_ready)

endmodule
